@@ src/ctk_pkg.sv @@
`timescale 1ns / 1ps
package ctk_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_WORD = 1'b1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORDS_IN_USE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMS_IN_USE  = 2'd2;

   localparam int TOP_COUNT_W = 5;
   localparam int WORDS_W     = 11;
   localparam int DIMS_W      = 7;
   localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 5'd1;
   localparam logic [WORDS_W-1:0]     WORDS_RESET     = 11'd1024;
   localparam logic [DIMS_W-1:0]      DIMS_RESET      = 7'd64;

   // cosine is scaled by 2^14, so the squared test carries 2^28
   localparam int SCORE_BITS  = 15;
   localparam int SCORE_SHIFT = 28;
   localparam logic [SCORE_BITS-1:0] SCORE_ONE = 15'd16384;

   typedef struct packed {
      logic               cmd;
      logic [9:0]         word_index;
      logic [5:0]         element_index;
      logic signed [15:0] element_value;
   } req_payload_type;

   typedef struct packed {
      logic [9:0]         match_index;
      logic signed [15:0] similarity;
      logic [3:0]         rank;
      logic               status;
      logic               last;
   } rsp_payload_type;

endpackage

@@ src/ctk_if.sv @@
`timescale 1ns / 1ps
interface ctk_req_if;
   logic                     valid;
   logic                     ready;
   ctk_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ctk_rsp_if;
   logic                     valid;
   logic                     ready;
   ctk_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/cosine_top_k_neighbour_search.sv @@
`timescale 1ns / 1ps
// Cosine similarity top-k search over a table of Q4.12 embedding vectors.
// req_ch carries items: cmd write stores one element in the table, cmd query
// names a word and returns its nearest neighbours on rsp_ch.
// csr_* writes top_count, words_in_use and dims_in_use; the user does so
// only while the block is idle, unenforced. Writes go back to back when idle.
// A query holds req_ch.ready low until its last result is taken. For each
// other word in use it reads both vectors an element at a time and forms
// the dot product and both norms (one shared 16x16 multiplier, one table read
// port), then a shift-add multiplier forms na*nb and dot*dot, and fifteen
// bisection steps, each with a shift-add multiply, find the score.
// Results leave best first, min(top_count, words_in_use-1) of them, the final
// one marked last; a query word at or above words_in_use gives one error item.
// Results sit in an output register; a stalled receiver simply holds them.
// Reset restores the register defaults and empties the result list; the
// table itself is not cleared and must be written before it is queried.
module cosine_top_k_neighbour_search #(
   parameter int VOCAB_SIZE = 1024,
   parameter int EMBED_DIM  = 64,
   parameter int MAX_TOP    = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   ctk_req_if.sink                           req_ch,
   ctk_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [ctk_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctk_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   localparam int VW   = $clog2(VOCAB_SIZE);
   localparam int CW   = $clog2(VOCAB_SIZE + 1);
   localparam int EW   = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
   localparam int DCW  = $clog2(EMBED_DIM + 1);
   localparam int KW   = $clog2(MAX_TOP + 1);
   localparam int KIW  = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int NW   = 31 + $clog2(EMBED_DIM);
   localparam int DW   = NW + 1;
   localparam int RW   = 2 * NW + ctk_pkg::SCORE_SHIFT;
   localparam int AW   = VW + EW;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_NEXT  = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_PMUL  = 4'd4;
   localparam logic [3:0] S_RMUL  = 4'd5;
   localparam logic [3:0] S_SRCH  = 4'd6;
   localparam logic [3:0] S_SMUL  = 4'd7;
   localparam logic [3:0] S_OFFER = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   localparam logic [2:0] PH_RD_Q  = 3'd0;
   localparam logic [2:0] PH_RD_C  = 3'd1;
   localparam logic [2:0] PH_CAP_B = 3'd2;
   localparam logic [2:0] PH_AB    = 3'd3;
   localparam logic [2:0] PH_AA    = 3'd4;
   localparam logic [2:0] PH_BB    = 3'd5;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [ctk_pkg::TOP_COUNT_W-1:0] top_cfg_ff, top_cfg_in;
   logic [ctk_pkg::WORDS_W-1:0]     words_cfg_ff, words_cfg_in;
   logic [ctk_pkg::DIMS_W-1:0]      dims_cfg_ff, dims_cfg_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [CW-1:0]   words_ff, words_in;
   logic [DCW-1:0]  dims_ff, dims_in;
   logic [DCW-1:0]  d_ff, d_in;
   logic [CW-1:0]   cand_ff, cand_in;
   logic [VW-1:0]   qw_ff, qw_in;
   logic signed [15:0] a_ff, a_in, b_ff, b_in;
   logic signed [DW-1:0] dot_ff, dot_in;
   logic [NW-1:0]   na_ff, na_in, nb_ff, nb_in;
   logic [RW-1:0]   mx_ff, mx_in, acc_ff, acc_in, p_ff, p_in, r_ff, r_in;
   logic [NW-1:0]   my_ff, my_in;
   logic [ctk_pkg::SCORE_BITS-1:0] m_ff, m_in;
   logic [3:0]      bit_ff, bit_in;
   logic signed [15:0] score_ff, score_in;
   logic signed [15:0] best_sc_ff [MAX_TOP];
   logic signed [15:0] best_sc_in [MAX_TOP];
   logic [VW-1:0]   best_ix_ff [MAX_TOP];
   logic [VW-1:0]   best_ix_in [MAX_TOP];
   logic [KW-1:0]   count_ff, count_in;
   logic [KIW-1:0]  out_ix_ff, out_ix_in;
   logic            rsp_valid_ff, rsp_valid_in;
   ctk_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [KW-1:0]   k_clamp;
   logic [CW-1:0]   words_clamp;
   logic [DCW-1:0]  dims_clamp;
   logic            req_fire, rsp_fire;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [15:0]     ram_rdata;
   logic signed [15:0] mul_x, mul_y;
   logic signed [31:0] mul_p;
   logic [NW-1:0]   mag;
   logic [ctk_pkg::SCORE_BITS-1:0] cand_m;
   logic [29:0]     cand_sq;
   logic [ctk_pkg::SCORE_BITS-1:0] m_final;
   logic [MAX_TOP-1:0] gt;
   logic            reject;
   logic [KIW-1:0]  ld_ix;
   ctk_pkg::rsp_payload_type entry_pl;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   always_comb begin
      if (32'(top_cfg_ff) < 1) k_clamp = KW'(1);
      else if (32'(top_cfg_ff) > MAX_TOP) k_clamp = KW'(MAX_TOP);
      else k_clamp = KW'(top_cfg_ff);
      if (32'(words_cfg_ff) < 2) words_clamp = CW'(2);
      else if (32'(words_cfg_ff) > VOCAB_SIZE) words_clamp = CW'(VOCAB_SIZE);
      else words_clamp = CW'(words_cfg_ff);
      if (32'(dims_cfg_ff) < 1) dims_clamp = DCW'(1);
      else if (32'(dims_cfg_ff) > EMBED_DIM) dims_clamp = DCW'(EMBED_DIM);
      else dims_clamp = DCW'(dims_cfg_ff);
   end

   // embedding table
   assign ram_we = req_fire && (req_ch.payload.cmd == ctk_pkg::CMD_WRITE)
                   && (32'(req_ch.payload.word_index) < VOCAB_SIZE)
                   && (32'(req_ch.payload.element_index) < EMBED_DIM);
   assign ram_waddr = {VW'(req_ch.payload.word_index),
                       EW'(req_ch.payload.element_index)};
   assign ram_raddr = (phase_ff == PH_RD_Q) ? {qw_ff, d_ff[EW-1:0]}
                                            : {cand_ff[VW-1:0], d_ff[EW-1:0]};

   ctk_ram #(
      .WIDTH (16),
      .DEPTH (VOCAB_SIZE << EW)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ch.payload.element_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared 16x16 multiplier for dot product and both norms
   always_comb begin
      mul_x = (phase_ff == PH_BB) ? b_ff : a_ff;
      mul_y = (phase_ff == PH_AA) ? a_ff : b_ff;
   end
   assign mul_p = mul_x * mul_y;

   assign mag = dot_ff[DW-1] ? NW'(-dot_ff) : NW'(dot_ff);
   assign cand_m = m_ff | (ctk_pkg::SCORE_BITS'(1) << bit_ff);
   assign cand_sq = cand_m * cand_m;

   always_comb begin
      m_final = (acc_ff <= r_ff) ? cand_m : m_ff;
      if (m_final > ctk_pkg::SCORE_ONE) m_final = ctk_pkg::SCORE_ONE;
   end

   // top list insertion, list kept in descending score order
   always_comb begin
      for (int j = 0; j < MAX_TOP; j++) begin
         gt[j] = (KW'(j) < count_ff) && (best_sc_ff[j] >= score_ff);
      end
      reject = (count_ff >= k_ff) && (score_ff <= best_sc_ff[KIW'(k_ff - KW'(1))]);
   end

   always_comb begin
      entry_pl.match_index = 10'(best_ix_ff[ld_ix]);
      entry_pl.similarity  = best_sc_ff[ld_ix];
      entry_pl.rank        = 4'(ld_ix);
      entry_pl.status      = ctk_pkg::STATUS_OK;
      entry_pl.last        = (KW'(ld_ix) + KW'(1)) == count_ff;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      top_cfg_in = top_cfg_ff;
      words_cfg_in = words_cfg_ff;
      dims_cfg_in = dims_cfg_ff;
      k_in = k_ff;
      words_in = words_ff;
      dims_in = dims_ff;
      d_in = d_ff;
      cand_in = cand_ff;
      qw_in = qw_ff;
      a_in = a_ff;
      b_in = b_ff;
      dot_in = dot_ff;
      na_in = na_ff;
      nb_in = nb_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      acc_in = acc_ff;
      p_in = p_ff;
      r_in = r_ff;
      m_in = m_ff;
      bit_in = bit_ff;
      score_in = score_ff;
      best_sc_in = best_sc_ff;
      best_ix_in = best_ix_ff;
      count_in = count_ff;
      out_ix_in = out_ix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ld_ix = KIW'(0);

      if (csr_write_en) begin
         unique case (csr_index)
            ctk_pkg::CSR_TOP_COUNT:    top_cfg_in = ctk_pkg::TOP_COUNT_W'(csr_write_data);
            ctk_pkg::CSR_WORDS_IN_USE: words_cfg_in = csr_write_data;
            ctk_pkg::CSR_DIMS_IN_USE:  dims_cfg_in = ctk_pkg::DIMS_W'(csr_write_data);
            default: ;
         endcase
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_fire && req_ch.payload.cmd == ctk_pkg::CMD_QUERY) begin
               if (32'(req_ch.payload.word_index) >= 32'(words_clamp)) begin
                  rsp_data_in.match_index = '0;
                  rsp_data_in.similarity = '0;
                  rsp_data_in.rank = '0;
                  rsp_data_in.status = ctk_pkg::STATUS_BAD_WORD;
                  rsp_data_in.last = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  qw_in = VW'(req_ch.payload.word_index);
                  k_in = k_clamp;
                  words_in = words_clamp;
                  dims_in = dims_clamp;
                  cand_in = '0;
                  count_in = '0;
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            if (cand_ff == words_ff) begin
               ld_ix = KIW'(0);
               out_ix_in = KIW'(0);
               rsp_data_in = entry_pl;
               rsp_valid_in = 1'b1;
               state_in = S_EMIT;
            end else if (cand_ff[VW-1:0] == qw_ff) begin
               cand_in = cand_ff + CW'(1);
            end else begin
               dot_in = '0;
               na_in = '0;
               nb_in = '0;
               d_in = '0;
               phase_in = PH_RD_Q;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            case (phase_ff)
               PH_RD_Q:  phase_in = PH_RD_C;
               PH_RD_C: begin
                  a_in = ram_rdata;
                  phase_in = PH_CAP_B;
               end
               PH_CAP_B: begin
                  b_in = ram_rdata;
                  phase_in = PH_AB;
               end
               PH_AB: begin
                  dot_in = dot_ff + DW'(mul_p);
                  phase_in = PH_AA;
               end
               PH_AA: begin
                  na_in = na_ff + NW'(unsigned'(mul_p));
                  phase_in = PH_BB;
               end
               default: begin
                  nb_in = nb_ff + NW'(unsigned'(mul_p));
                  d_in = d_ff + DCW'(1);
                  phase_in = PH_RD_Q;
                  if (d_ff + DCW'(1) == dims_ff) state_in = S_NORM;
               end
            endcase
         end
         S_NORM: begin
            if (na_ff == '0 || nb_ff == '0) begin
               score_in = '0;
               state_in = S_OFFER;
            end else begin
               mx_in = RW'(na_ff);
               my_in = nb_ff;
               acc_in = '0;
               state_in = S_PMUL;
            end
         end
         S_PMUL, S_RMUL, S_SMUL: begin
            if (my_ff == '0) begin
               if (state_ff == S_PMUL) begin
                  p_in = acc_ff;
                  mx_in = RW'(mag);
                  my_in = mag;
                  acc_in = '0;
                  state_in = S_RMUL;
               end else if (state_ff == S_RMUL) begin
                  r_in = acc_ff << ctk_pkg::SCORE_SHIFT;
                  m_in = '0;
                  bit_in = 4'(ctk_pkg::SCORE_BITS - 1);
                  state_in = S_SRCH;
               end else begin
                  m_in = (acc_ff <= r_ff) ? cand_m : m_ff;
                  if (bit_ff == 4'd0) begin
                     score_in = dot_ff[DW-1] ? -$signed({1'b0, m_final})
                                             : $signed({1'b0, m_final});
                     state_in = S_OFFER;
                  end else begin
                     bit_in = bit_ff - 4'd1;
                     state_in = S_SRCH;
                  end
               end
            end else begin
               // shift-add step, one multiplier bit a cycle
               if (my_ff[0]) acc_in = acc_ff + mx_ff;
               mx_in = mx_ff << 1;
               my_in = my_ff >> 1;
            end
         end
         S_SRCH: begin
            mx_in = p_ff;
            my_in = NW'(cand_sq);
            acc_in = '0;
            state_in = S_SMUL;
         end
         S_OFFER: begin
            if (!reject) begin
               for (int j = 0; j < MAX_TOP; j++) begin
                  if (KW'(j) < k_ff && !gt[j]) begin
                     if (j == 0) begin
                        best_sc_in[j] = score_ff;
                        best_ix_in[j] = cand_ff[VW-1:0];
                     end else if (gt[j-1]) begin
                        best_sc_in[j] = score_ff;
                        best_ix_in[j] = cand_ff[VW-1:0];
                     end else begin
                        best_sc_in[j] = best_sc_ff[j-1];
                        best_ix_in[j] = best_ix_ff[j-1];
                     end
                  end
               end
               if (count_ff < k_ff) count_in = count_ff + KW'(1);
            end
            cand_in = cand_ff + CW'(1);
            state_in = S_NEXT;
         end
         S_EMIT: begin
            if (rsp_fire) begin
               if (rsp_data_ff.last) begin
                  rsp_valid_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  ld_ix = out_ix_ff + KIW'(1);
                  out_ix_in = ld_ix;
                  rsp_data_in = entry_pl;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_RD_Q;
         top_cfg_ff <= ctk_pkg::TOP_COUNT_RESET;
         words_cfg_ff <= ctk_pkg::WORDS_RESET;
         dims_cfg_ff <= ctk_pkg::DIMS_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         top_cfg_ff <= top_cfg_in;
         words_cfg_ff <= words_cfg_in;
         dims_cfg_ff <= dims_cfg_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in;
      words_ff <= words_in;
      dims_ff <= dims_in;
      d_ff <= d_in;
      cand_ff <= cand_in;
      qw_ff <= qw_in;
      a_ff <= a_in;
      b_ff <= b_in;
      dot_ff <= dot_in;
      na_ff <= na_in;
      nb_ff <= nb_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      acc_ff <= acc_in;
      p_ff <= p_in;
      r_ff <= r_in;
      m_ff <= m_in;
      bit_ff <= bit_in;
      score_ff <= score_in;
      best_sc_ff <= best_sc_in;
      best_ix_ff <= best_ix_in;
      out_ix_ff <= out_ix_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_EMIT) |-> (count_ff <= k_ff))
      else $error("result list longer than top_count");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_valid_ff))
      else $error("item accepted while a result is pending");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == ctk_pkg::STATUS_BAD_WORD)
         |-> rsp_data_ff.last)
      else $error("error result not marked last");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data_ff.last) |=> (state_ff == S_IDLE && !rsp_valid_ff))
      else $error("block not idle after final result");
`endif
endmodule

@@ src/ctk_ram.sv @@
`timescale 1ns / 1ps
module ctk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
